/* hdl/fpa_pkg.sv */
package fpa_pkg;

  localparam int WORD_BITS = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_LT  = 4'd4,
    OP_GT  = 4'd5,
    OP_LE  = 4'd6,
    OP_GE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9,
    OP_MIN = 4'd10,
    OP_MAX = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIVZERO  = 2'd2
  } status_t;

  // Sideband that travels alongside the divider.
  typedef struct packed {
    logic [3:0]           op;
    logic                 neg;
    logic [WORD_BITS-1:0] res;
    logic                 cmp;
    logic [1:0]           status;
    logic [63:0]          prod;
  } side_t;

endpackage

/* hdl/fpa_front.sv */
module fpa_front #(
  parameter int FRACTION_BITS = 8,
  parameter int NB = 41
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [3:0]                        in_op,
  input  logic [fpa_pkg::WORD_BITS-1:0]     in_a,
  input  logic [fpa_pkg::WORD_BITS-1:0]     in_b,
  output logic                              out_vld,
  output fpa_pkg::side_t                    out_side,
  output logic [NB-1:0]                     out_num,
  output logic [fpa_pkg::WORD_BITS-1:0]     out_den
);

  localparam int W = fpa_pkg::WORD_BITS;

  logic                v1_r;
  logic [3:0]          op1_r;
  logic signed [W-1:0] a1_r, b1_r;

  logic                v2_r;
  fpa_pkg::side_t      side2_r, side2_nxt;
  logic [W-1:0]        mag_a2_r, mag_b2_r, mag_a_nxt, mag_b_nxt;

  logic                v3_r;
  fpa_pkg::side_t      side3_r, side3_nxt;
  logic [NB-1:0]       num3_r;
  logic [W-1:0]        den3_r;

  logic [W:0]          sum, dif;
  logic                lt, eq;

  always_comb begin
    sum = {a1_r[W-1], a1_r} + {b1_r[W-1], b1_r};
    dif = {a1_r[W-1], a1_r} - {b1_r[W-1], b1_r};
    lt  = a1_r < b1_r;
    eq  = a1_r == b1_r;
    mag_a_nxt = a1_r[W-1] ? W'(-a1_r) : a1_r;
    mag_b_nxt = b1_r[W-1] ? W'(-b1_r) : b1_r;
    side2_nxt        = '0;
    side2_nxt.op     = op1_r;
    side2_nxt.neg    = a1_r[W-1] ^ b1_r[W-1];
    case (op1_r)
      fpa_pkg::OP_ADD: begin
        if (sum[W] != sum[W-1]) begin
          side2_nxt.res    = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          side2_nxt.status = fpa_pkg::ST_OVERFLOW;
        end else begin
          side2_nxt.res = sum[W-1:0];
        end
      end
      fpa_pkg::OP_SUB: begin
        if (dif[W] != dif[W-1]) begin
          side2_nxt.res    = dif[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          side2_nxt.status = fpa_pkg::ST_OVERFLOW;
        end else begin
          side2_nxt.res = dif[W-1:0];
        end
      end
      fpa_pkg::OP_DIV: begin
        if (b1_r == '0) side2_nxt.status = fpa_pkg::ST_DIVZERO;
      end
      fpa_pkg::OP_LT:  side2_nxt.cmp = lt;
      fpa_pkg::OP_GT:  side2_nxt.cmp = !lt && !eq;
      fpa_pkg::OP_LE:  side2_nxt.cmp = lt || eq;
      fpa_pkg::OP_GE:  side2_nxt.cmp = !lt;
      fpa_pkg::OP_EQ:  side2_nxt.cmp = eq;
      fpa_pkg::OP_NE:  side2_nxt.cmp = !eq;
      fpa_pkg::OP_MIN: side2_nxt.res = lt ? a1_r : b1_r;
      fpa_pkg::OP_MAX: side2_nxt.res = (!lt && !eq) ? a1_r : b1_r;
      default: ;
    endcase
  end

  always_comb begin
    side3_nxt      = side2_r;
    side3_nxt.prod = 64'(mag_a2_r) * 64'(mag_b2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    op1_r    <= in_op;
    a1_r     <= in_a;
    b1_r     <= in_b;
    side2_r  <= side2_nxt;
    mag_a2_r <= mag_a_nxt;
    mag_b2_r <= mag_b_nxt;
    side3_r  <= side3_nxt;
    num3_r   <= NB'(mag_a2_r) << (FRACTION_BITS + 1);
    den3_r   <= mag_b2_r;
  end

  assign out_vld  = v3_r;
  assign out_side = side3_r;
  assign out_num  = num3_r;
  assign out_den  = den3_r;

endmodule

/* hdl/fpa_divider.sv */
module fpa_divider #(
  parameter int NB = 41
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  fpa_pkg::side_t                in_side,
  input  logic [NB-1:0]                 in_num,
  input  logic [fpa_pkg::WORD_BITS-1:0] in_den,
  output logic                          out_vld,
  output fpa_pkg::side_t                out_side,
  output logic [NB-1:0]                 out_quot
);

  localparam int W = fpa_pkg::WORD_BITS;

  logic           vld_r  [0:NB];
  fpa_pkg::side_t side_r [0:NB];
  logic [NB-1:0]  num_r  [0:NB];
  logic [NB-1:0]  quot_r [0:NB];
  logic [W-1:0]   rem_r  [0:NB];
  logic [W-1:0]   den_r  [0:NB];

  always_comb begin
    vld_r[0]  = in_vld;
    side_r[0] = in_side;
    num_r[0]  = in_num;
    quot_r[0] = '0;
    rem_r[0]  = '0;
    den_r[0]  = in_den;
  end

  // One quotient bit per stage, restoring division.
  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [W:0] trial;
    logic       ge;
    always_comb begin
      trial = {rem_r[i], num_r[i][NB-1]};
      ge    = trial >= {1'b0, den_r[i]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      side_r[i+1] <= side_r[i];
      den_r[i+1]  <= den_r[i];
      num_r[i+1]  <= num_r[i] << 1;
      quot_r[i+1] <= {quot_r[i][NB-2:0], ge};
      rem_r[i+1]  <= ge ? W'(trial - {1'b0, den_r[i]}) : trial[W-1:0];
    end
  end

  assign out_vld  = vld_r[NB];
  assign out_side = side_r[NB];
  assign out_quot = quot_r[NB];

endmodule

/* hdl/fpa_post.sv */
module fpa_post #(
  parameter int FRACTION_BITS = 8,
  parameter int NB = 41
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  fpa_pkg::side_t                in_side,
  input  logic [NB-1:0]                 in_quot,
  output logic                          out_vld,
  output logic [fpa_pkg::WORD_BITS-1:0] out_res,
  output logic                          out_cmp,
  output logic [1:0]                    out_status
);

  localparam int W = fpa_pkg::WORD_BITS;
  localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

  logic           va_r, vb_r;
  fpa_pkg::side_t sa_r;
  logic [63:0]    mag_r, mag_nxt;
  logic           arith;
  logic           over;
  logic [W-1:0]   res_r, res_nxt;
  logic           cmp_r;
  logic [1:0]     st_r, st_nxt;

  always_comb begin
    if (in_side.op == fpa_pkg::OP_MUL) begin
      mag_nxt = (in_side.prod + HALF) >> FRACTION_BITS;
    end else begin
      mag_nxt = (64'(in_quot) + 64'd1) >> 1;
    end
  end

  always_comb begin
    arith = (sa_r.op == fpa_pkg::OP_MUL) ||
            (sa_r.op == fpa_pkg::OP_DIV && sa_r.status == fpa_pkg::ST_OK);
    over  = sa_r.neg ? (mag_r > (64'd1 << (W - 1)))
                     : (mag_r > ((64'd1 << (W - 1)) - 64'd1));
    res_nxt = sa_r.res;
    st_nxt  = sa_r.status;
    if (arith) begin
      if (over) begin
        res_nxt = sa_r.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        st_nxt  = fpa_pkg::ST_OVERFLOW;
      end else begin
        res_nxt = sa_r.neg ? W'(-mag_r[W-1:0]) : mag_r[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_vld;
      vb_r <= va_r;
    end
    sa_r  <= in_side;
    mag_r <= mag_nxt;
    res_r <= res_nxt;
    cmp_r <= sa_r.cmp;
    st_r  <= st_nxt;
  end

  assign out_vld    = vb_r;
  assign out_res    = res_r;
  assign out_cmp    = cmp_r;
  assign out_status = st_r;

endmodule

/* hdl/fixed_point_alu.sv */
// Fixed-point arithmetic unit for signed raw values with FRACTION_BITS
// fractional bits in a 32-bit two's complement word.
// An operation is taken at a rising edge where start is high and busy is
// low; busy is always low, so a new beat can be issued every cycle.
// Each beat carries an opcode and two raw operands. Exactly one result beat
// comes back for every accepted beat, in order, marked by out_valid for a
// single cycle. The receiver cannot hold results off and needs none.
// Every opcode takes the same path: three front stages, one restoring
// division stage per quotient bit (33 + FRACTION_BITS of them) and two
// rounding and saturation stages. Throughput is one beat per cycle.
// Multiply and divide round half away from zero and saturate on overflow
// with status 1; division by zero gives result zero and status 2.
// Synchronous reset clears every valid bit, so no result appears until a
// new beat has passed through the whole pipeline.
module fixed_point_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  output logic signed [31:0] out_result_raw,
  output logic               out_compare_true,
  output logic [1:0]         out_status
);

  localparam int W   = fpa_pkg::WORD_BITS;
  // Width of the scaled dividend and of the quotient.
  localparam int NB  = W + FRACTION_BITS + 1;
  localparam int LAT = NB + 5;

  logic                fr_vld, dv_vld;
  fpa_pkg::side_t      fr_side, dv_side;
  logic [NB-1:0]       fr_num, dv_quot;
  logic [W-1:0]        fr_den;
  logic [W-1:0]        res;

  // The pipeline never stalls.
  assign busy = 1'b0;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS), .NB(NB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_op    (in_opcode),
    .in_a     (in_operand_a),
    .in_b     (in_operand_b),
    .out_vld  (fr_vld),
    .out_side (fr_side),
    .out_num  (fr_num),
    .out_den  (fr_den)
  );

  fpa_divider #(.NB(NB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_num   (fr_num),
    .in_den   (fr_den),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_quot (dv_quot)
  );

  fpa_post #(.FRACTION_BITS(FRACTION_BITS), .NB(NB)) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (dv_vld),
    .in_side    (dv_side),
    .in_quot    (dv_quot),
    .out_vld    (out_valid),
    .out_res    (res),
    .out_cmp    (out_compare_true),
    .out_status (out_status)
  );

  assign out_result_raw = res;

  // Every accepted beat produces its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result beat missing after fixed latency");

  // A division by zero always reports a zero result.
  a_divzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == fpa_pkg::ST_DIVZERO) |-> out_result_raw == '0)
    else $error("division by zero with non-zero result");

  // A true compare carries neither a result value nor a status.
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_true) |->
      (out_result_raw == '0 && out_status == fpa_pkg::ST_OK))
    else $error("compare beat with result or status");

endmodule

/* tb/sv/fixed_point_alu_tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the fixed-point arithmetic unit.
// A table of directed beats comes first, then random beats. Every accepted
// beat is run through a local prediction of the unit, and the expected
// result is queued. Each result beat marked by out_valid is compared with
// the oldest queued expectation, field by field.
module fixed_point_alu_tb;

  localparam int FRAC    = 8;
  localparam int LATENCY = 38 + FRAC;
  localparam int N_RAND  = 1500;

  typedef struct packed {
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  status;
  } alu_res_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    alu_res_t    want;
  } beat_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_opcode;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic        out_valid;
  logic [31:0] out_result_raw;
  logic        out_compare_true;
  logic [1:0]  out_status;

  alu_res_t pending_results[$];
  int       n_errors;

  fixed_point_alu #(.FRACTION_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .out_valid(out_valid),
    .out_result_raw(out_result_raw), .out_compare_true(out_compare_true),
    .out_status(out_status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Clamp a wide signed value into the 32-bit range, raising overflow.
  function automatic alu_res_t clamp_word(logic signed [127:0] v);
    alu_res_t r;
    r = '0;
    if (v > 128'sd2147483647) begin
      r.res = 32'h7fff_ffff;
      r.status = fpa_pkg::ST_OVERFLOW;
    end else if (v < -128'sd2147483648) begin
      r.res = 32'h8000_0000;
      r.status = fpa_pkg::ST_OVERFLOW;
    end else begin
      r.res = v[31:0];
    end
    return r;
  endfunction

  // Predicted result of one operation. Multiply and divide work on
  // magnitudes so that rounding goes half away from zero.
  function automatic alu_res_t alu_predict(logic [3:0] op, logic [31:0] a_raw,
                                           logic [31:0] b_raw);
    logic signed [127:0] sa, sb, p;
    logic [127:0] ma, mb, q;
    bit neg;
    alu_res_t r;
    sa = {{96{a_raw[31]}}, a_raw};
    sb = {{96{b_raw[31]}}, b_raw};
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    neg = a_raw[31] ^ b_raw[31];
    r = '0;
    case (op)
      fpa_pkg::OP_ADD: r = clamp_word(sa + sb);
      fpa_pkg::OP_SUB: r = clamp_word(sa - sb);
      fpa_pkg::OP_MUL: begin
        q = (ma * mb + (128'd1 << (FRAC - 1))) >> FRAC;
        p = neg ? -$signed(q) : $signed(q);
        r = clamp_word(p);
      end
      fpa_pkg::OP_DIV: begin
        if (b_raw == 32'd0) begin
          r.status = fpa_pkg::ST_DIVZERO;
        end else begin
          q = (((ma << (FRAC + 1)) / mb) + 128'd1) >> 1;
          p = neg ? -$signed(q) : $signed(q);
          r = clamp_word(p);
        end
      end
      fpa_pkg::OP_LT:  r.cmp = sa < sb;
      fpa_pkg::OP_GT:  r.cmp = sa > sb;
      fpa_pkg::OP_LE:  r.cmp = sa <= sb;
      fpa_pkg::OP_GE:  r.cmp = sa >= sb;
      fpa_pkg::OP_EQ:  r.cmp = sa == sb;
      fpa_pkg::OP_NE:  r.cmp = sa != sb;
      fpa_pkg::OP_MIN: r.res = sa < sb ? a_raw : b_raw;
      fpa_pkg::OP_MAX: r.res = sa > sb ? a_raw : b_raw;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat res=%h cmp=%b st=%0d", $time,
                 out_result_raw, out_compare_true, out_status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_raw !== want.res) begin
          $display("%0t: result_raw expected %h actual %h", $time, want.res,
                   out_result_raw);
          n_errors++;
        end
        if (out_compare_true !== want.cmp) begin
          $display("%0t: compare_true expected %b actual %b", $time, want.cmp,
                   out_compare_true);
          n_errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_status);
          n_errors++;
        end
      end
    end
  end

  beat_row_t directed[$];

  function automatic beat_row_t mk_row(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                       bit typed, logic [31:0] res, logic cmp,
                                       logic [1:0] st);
    beat_row_t row;
    row.op = op; row.a = a; row.b = b; row.typed = typed;
    row.want.res = res; row.want.cmp = cmp; row.want.status = st;
    return row;
  endfunction

  // Drive one beat and hold it until it is taken. The expectation is
  // queued at the accepting edge so that it is always ahead of its result.
  task automatic send_beat(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                           bit typed, alu_res_t want, bit may_idle);
    alu_res_t expd;
    while (may_idle && $urandom_range(99) < 21) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    expd = alu_predict(op, a, b);
    if (typed && expd !== want) begin
      $display("%0t: table row op=%0d expected %h actual %h", $time, op, want,
               expd);
      n_errors++;
    end
    pending_results.push_back(typed ? want : expd);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return {$urandom_range(1) ? 24'hffffff : 24'h0, 8'($urandom)};
      1: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      2: return 32'($signed(16'($urandom)));
      3: return {$urandom_range(1) ? 20'hfffff : 20'h0, 12'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    alu_res_t none;
    logic [3:0] op;
    logic [31:0] a, b;
    bit quiet;
    none = '0;
    n_errors = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = '0;
    in_operand_a = '0;
    in_operand_b = '0;

    // Rows with typed answers: saturation bounds, plain sums and products,
    // division by zero, unused opcodes, the plain compares and min and max.
    directed.push_back(mk_row(fpa_pkg::OP_ADD, 32'h7fff_ffff, 32'h1, 1'b1, 32'h7fff_ffff,
                              1'b0, fpa_pkg::ST_OVERFLOW));
    directed.push_back(mk_row(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h1, 1'b1, 32'h8000_0000,
                              1'b0, fpa_pkg::ST_OVERFLOW));
    directed.push_back(mk_row(fpa_pkg::OP_ADD, 32'h100, 32'h200, 1'b1, 32'h300, 1'b0,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_MUL, 32'h100, 32'h100, 1'b1, 32'h100, 1'b0,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1,
                              32'h7fff_ffff, 1'b0, fpa_pkg::ST_OVERFLOW));
    directed.push_back(mk_row(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
                              32'h8000_0000, 1'b0, fpa_pkg::ST_OVERFLOW));
    directed.push_back(mk_row(fpa_pkg::OP_DIV, 32'h1234, 32'h0, 1'b1, 32'h0, 1'b0,
                              fpa_pkg::ST_DIVZERO));
    directed.push_back(mk_row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0, 1'b1, 32'h0, 1'b0,
                              fpa_pkg::ST_DIVZERO));
    directed.push_back(mk_row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h1, 1'b1, 32'h8000_0000,
                              1'b0, fpa_pkg::ST_OVERFLOW));
    directed.push_back(mk_row(fpa_pkg::OP_LT, 32'hffff_ffff, 32'h0, 1'b1, 32'h0, 1'b1,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_GT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h0,
                              1'b0, fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_LE, 32'h5, 32'h5, 1'b1, 32'h0, 1'b1,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_GE, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0,
                              1'b1, fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_EQ, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h0,
                              1'b1, fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_NE, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h0,
                              1'b0, fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
                              32'h8000_0000, 1'b0, fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
                              32'h7fff_ffff, 1'b0, fpa_pkg::ST_OK));
    directed.push_back(mk_row(4'd12, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0, 1'b0,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(4'd15, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h0, 1'b0,
                              fpa_pkg::ST_OK));
    // Rounding ties and signs are left to the prediction.
    directed.push_back(mk_row(fpa_pkg::OP_MUL, 32'h80, 32'h1, 1'b0, '0, 1'b0,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_MUL, 32'hffff_ff80, 32'h1, 1'b0, '0, 1'b0,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_DIV, 32'h1, 32'h200, 1'b0, '0, 1'b0,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_DIV, 32'hffff_ffff, 32'h200, 1'b0, '0, 1'b0,
                              fpa_pkg::ST_OK));
    directed.push_back(mk_row(fpa_pkg::OP_DIV, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, '0,
                              1'b0, fpa_pkg::ST_OK));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_beat(directed[i].op, directed[i].a, directed[i].b, directed[i].typed,
                directed[i].want, 1'b1);

    // Hold the sender off until the pipeline has drained completely.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RAND; n++) begin
      // A burst in the middle runs back to back with no idle cycles.
      quiet = (n >= 600 && n < 900);
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      a = rand_operand();
      b = ($urandom_range(15) == 0) ? 32'h0 : rand_operand();
      if ($urandom_range(9) == 0) b = a;
      send_beat(op, a, b, 1'b0, none, !quiet);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung pipeline.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
